@@ hdl/svt_pkg.sv @@
// Shared types and constants for the sorted value table.
// Depends on nothing; every other file in hdl/ refers to it by scoped names.
`timescale 1ns / 1ps

package svt_pkg;

    // Table depth and the widths derived from it
    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    // Widths of the item fields
    localparam int VAL_W = 32;
    localparam int POS_W = 8;
    localparam int FILL_W = 5;
    localparam int CMP_W = POS_W + 1;

    typedef enum logic [1:0] {
        MODE_INSERT   = 2'd0,
        MODE_READ     = 2'd1,
        MODE_DEL_MIN  = 2'd2,
        MODE_DEL_MAX  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_ABSENT = 2'd1,
        ST_FULL   = 2'd2
    } status_t;

    typedef struct packed {
        mode_t                     mode;
        logic signed [VAL_W-1:0]   value;
        logic [POS_W-1:0]          position;
    } req_item_t;

    typedef struct packed {
        status_t                   status;
        logic signed [VAL_W-1:0]   read_value;
        logic [FILL_W-1:0]         fill_count;
    } rsp_item_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;   // capture the request item
        logic exec;   // run the operation, update the table, load the result
    } dp_cmd_t;

    // Controller states, one-hot
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } ctrl_state_t;

endpackage

@@ hdl/svt_ctrl.sv @@
// Controller for the sorted value table: sequences one item at a time.
// Depends on svt_pkg; drives the commands of svt_datapath.
`timescale 1ns / 1ps

module svt_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output svt_pkg::dp_cmd_t cmd
);

    svt_pkg::ctrl_state_t state_reg;
    svt_pkg::ctrl_state_t state_next;
    logic                 rsp_valid_reg;
    logic                 rsp_valid_next;
    logic                 out_free;

    // Output register can take a new result when empty or draining now
    assign out_free = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        state_next = state_reg;
        cmd.load   = 1'b0;
        cmd.exec   = 1'b0;
        case (state_reg)
            svt_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = svt_pkg::S_EXEC;
                end
            end
            svt_pkg::S_EXEC:
            begin
                if (out_free)
                begin
                    cmd.exec   = 1'b1;
                    state_next = svt_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = svt_pkg::S_IDLE;
            end
        endcase
    end

    assign rsp_valid_next = cmd.exec || (rsp_valid_reg && rsp_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= svt_pkg::S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign req_stall = (state_reg != svt_pkg::S_IDLE);
    assign rsp_valid = rsp_valid_reg;

endmodule

@@ hdl/svt_datapath.sv @@
// Datapath for the sorted value table: entry cells, count and result register.
// Depends on svt_pkg; commanded by svt_ctrl.
`timescale 1ns / 1ps

module svt_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  svt_pkg::dp_cmd_t   cmd,
    input  svt_pkg::req_item_t req,
    output svt_pkg::rsp_item_t rsp
);

    svt_pkg::req_item_t                   op_reg;
    logic signed [svt_pkg::VAL_W-1:0]     entries_reg  [svt_pkg::DEPTH];
    logic signed [svt_pkg::VAL_W-1:0]     entries_next [svt_pkg::DEPTH];
    logic [svt_pkg::CNT_W-1:0]            count_reg;
    logic [svt_pkg::CNT_W-1:0]            count_next;
    svt_pkg::rsp_item_t                   rsp_reg;
    svt_pkg::rsp_item_t                   rsp_next;

    logic [svt_pkg::DEPTH-1:0]            lt;
    logic                                 full;
    logic                                 empty;
    logic                                 pos_ok;
    logic [svt_pkg::IDX_W-1:0]            rd_addr;
    logic signed [svt_pkg::VAL_W-1:0]     rd_data;

    assign full  = (count_reg == svt_pkg::CNT_W'(svt_pkg::DEPTH));
    assign empty = (count_reg == '0);
    assign pos_ok = (op_reg.position != '0) &&
                    (svt_pkg::CMP_W'(op_reg.position) <= svt_pkg::CMP_W'(count_reg));

    // Every occupied cell compares against the new value at once
    always_comb
    begin
        for (int i = 0; i < svt_pkg::DEPTH; i++)
        begin
            lt[i] = (svt_pkg::CNT_W'(i) < count_reg) && (entries_reg[i] < op_reg.value);
        end
    end

    // Single read port: address picked by the operation
    always_comb
    begin
        case (op_reg.mode)
            svt_pkg::MODE_READ:    rd_addr = svt_pkg::IDX_W'(op_reg.position - 1'b1);
            svt_pkg::MODE_DEL_MAX: rd_addr = svt_pkg::IDX_W'(count_reg - 1'b1);
            default:               rd_addr = '0;
        endcase
    end

    assign rd_data = entries_reg[rd_addr];

    always_comb
    begin
        for (int i = 0; i < svt_pkg::DEPTH; i++)
        begin
            entries_next[i] = entries_reg[i];
        end
        count_next          = count_reg;
        rsp_next.status     = svt_pkg::ST_OK;
        rsp_next.read_value = '0;
        case (op_reg.mode)
            svt_pkg::MODE_INSERT:
            begin
                if (full)
                begin
                    rsp_next.status = svt_pkg::ST_FULL;
                end
                else
                begin
                    // Hold cells below the slot, drop the value in, shift the rest up
                    if (!lt[0])
                        entries_next[0] = op_reg.value;
                    for (int i = 1; i < svt_pkg::DEPTH; i++)
                    begin
                        if (lt[i])
                            entries_next[i] = entries_reg[i];
                        else if (lt[i-1])
                            entries_next[i] = op_reg.value;
                        else
                            entries_next[i] = entries_reg[i-1];
                    end
                    count_next = count_reg + 1'b1;
                end
            end
            svt_pkg::MODE_READ:
            begin
                if (pos_ok)
                    rsp_next.read_value = rd_data;
                else
                    rsp_next.status = svt_pkg::ST_ABSENT;
            end
            svt_pkg::MODE_DEL_MIN:
            begin
                if (empty)
                begin
                    rsp_next.status = svt_pkg::ST_ABSENT;
                end
                else
                begin
                    rsp_next.read_value = rd_data;
                    for (int i = 0; i < svt_pkg::DEPTH - 1; i++)
                    begin
                        entries_next[i] = entries_reg[i+1];
                    end
                    count_next = count_reg - 1'b1;
                end
            end
            svt_pkg::MODE_DEL_MAX:
            begin
                if (empty)
                begin
                    rsp_next.status = svt_pkg::ST_ABSENT;
                end
                else
                begin
                    rsp_next.read_value = rd_data;
                    count_next          = count_reg - 1'b1;
                end
            end
            default:
            begin
                rsp_next.status = svt_pkg::ST_ABSENT;
            end
        endcase
        rsp_next.fill_count = svt_pkg::FILL_W'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.exec)
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= req;
        end
        if (cmd.exec)
        begin
            rsp_reg <= rsp_next;
            for (int i = 0; i < svt_pkg::DEPTH; i++)
            begin
                entries_reg[i] <= entries_next[i];
            end
        end
    end

    assign rsp = rsp_reg;

endmodule

@@ hdl/sorted_value_table.sv @@
// Top level of the sorted value table: ascending table of signed 32-bit values.
// Depends on svt_pkg, svt_ctrl and svt_datapath.
//
//   channel | valid     | stall     | payload
//   --------+-----------+-----------+-----------------------------------
//   request | req_valid | req_stall | req  (mode, value, position)
//   result  | rsp_valid | rsp_stall | rsp  (status, read_value, fill_count)
//
// Each item is captured in the accept cycle; in S_EXEC the controller then runs the
// operation on all cells in parallel and loads the result register.
// The pace is set by the controller, which holds one item at a time.
// A stalled result holds the operation cycle back; a new item is still taken
// while the previous result waits in the output register.
// Reset (rst_n low, asynchronous) empties the table; cell contents stay undefined.
`timescale 1ns / 1ps

module sorted_value_table (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  svt_pkg::req_item_t req,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output svt_pkg::rsp_item_t rsp
);

    // Commands from controller to datapath
    svt_pkg::dp_cmd_t cmd;

    // Sequence accept, execute and result handoff
    svt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd)
    );

    // Hold the cells, the count and the result register
    svt_datapath u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .req   (req),
        .rsp   (rsp)
    );

endmodule

@@ hdl/svt_checker.sv @@
// Port-level checker for the sorted value table, bound to the top level.
// Depends on svt_pkg and sorted_value_table.
`timescale 1ns / 1ps

module svt_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_stall,
    input svt_pkg::req_item_t req,
    input logic               rsp_valid,
    input logic               rsp_stall,
    input svt_pkg::rsp_item_t rsp
);

    // A stalled request item stays and does not change
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_stall |=> req_valid && $stable(req))
        else $error("stalled request changed or dropped");

    // A stalled result stays and does not change
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled result changed or dropped");

    // One item at a time: an accept closes the request side next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request accepted while an item was in work");

    // A full flag only comes with a full table
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == svt_pkg::ST_FULL |->
            rsp.fill_count == svt_pkg::FILL_W'(svt_pkg::DEPTH))
        else $error("full status with table not full");

    // A failed operation returns zero
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status != svt_pkg::ST_OK |-> rsp.read_value == '0)
        else $error("nonzero value on failed operation");

endmodule

bind sorted_value_table svt_checker u_svt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);
